FILE: src/gts_pkg.sv
// Shared widths, register codes, payload structs and the dither table of the Gouraud shader.
package gts_pkg;

	localparam int LINE_WIDTH_DEF = 1024;

	localparam int VX_W      = 11;
	localparam int CRD_W     = 13;
	localparam int DIF_W     = 14;
	localparam int PRD_W     = 28;
	localparam int EDG_W     = 29;
	localparam int AREA_W    = 23;
	localparam int CH_W      = 8;
	localparam int SUM_W     = 31;
	localparam int QUO_W     = 8;
	localparam int ADDR_W    = 19;
	localparam int BX_W      = 10;
	localparam int BY_W      = 9;
	localparam int COL_W     = 24;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int DTH_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_DRAW_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd5;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [BX_W-1:0] BOX_X_LIM = 10'd1023;
	localparam logic [BY_W-1:0] BOX_Y_LIM = 9'd511;

	typedef logic signed [CRD_W-1:0] crd_t;

	// Setup results: ordered vertices after offset, area, and clipped box.
	typedef struct packed {
		crd_t [2:0]                 ox;
		crd_t [2:0]                 oy;
		logic [2:0][COL_W-1:0]      oc;
		logic [AREA_W-1:0]          area;
		logic [BX_W-1:0]            xmin;
		logic [BY_W-1:0]            ymin;
		logic [BX_W-1:0]            xmax;
		logic [BY_W-1:0]            ymax;
	} geo_t;

	// Per-item sideband that rides along with the color data.
	typedef struct packed {
		logic                       wr;
		logic [ADDR_W-1:0]          addr;
		logic signed [DTH_W-1:0]    dith;
		logic [BX_W-1:0]            xmin;
		logic [BY_W-1:0]            ymin;
		logic [BX_W-1:0]            xmax;
		logic [BY_W-1:0]            ymax;
	} side_t;

	function automatic logic signed [DTH_W-1:0] dither(input logic [3:0] idx);
		logic signed [DTH_W-1:0] d;
		unique case (idx)
			4'd0:  d = -4'sd4;
			4'd1:  d =  4'sd0;
			4'd2:  d = -4'sd3;
			4'd3:  d =  4'sd1;
			4'd4:  d =  4'sd2;
			4'd5:  d = -4'sd2;
			4'd6:  d =  4'sd3;
			4'd7:  d = -4'sd1;
			4'd8:  d = -4'sd3;
			4'd9:  d =  4'sd1;
			4'd10: d = -4'sd4;
			4'd11: d =  4'sd0;
			4'd12: d =  4'sd3;
			4'd13: d = -4'sd1;
			4'd14: d =  4'sd2;
			4'd15: d = -4'sd2;
		endcase
		return d;
	endfunction

endpackage

FILE: src/gts_setup.sv
// Vertex and clip registers with the triangle setup pipeline (winding, area, order, box).
module gts_setup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load_we,
	input  logic [1:0]                          slot,
	input  logic signed [gts_pkg::VX_W-1:0]     vx,
	input  logic signed [gts_pkg::VX_W-1:0]     vy,
	input  logic [gts_pkg::COL_W-1:0]           vc,
	input  logic                                cfg_we,
	input  logic [gts_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [gts_pkg::CFG_W-1:0]           cfg_data,
	output gts_pkg::geo_t                       geo
);

	logic signed [gts_pkg::VX_W-1:0]  vx_q [3];
	logic signed [gts_pkg::VX_W-1:0]  vy_q [3];
	logic [gts_pkg::COL_W-1:0]        vc_q [3];

	logic [gts_pkg::BX_W-1:0]  left_q, right_q;
	logic [gts_pkg::BY_W-1:0]  top_q, bottom_q;
	logic [gts_pkg::VX_W-1:0]  offx_q, offy_q;

	logic signed [11:0] dx1, dy2, dy1, dx2;
	logic signed [23:0] pa_q, pb_q;
	logic signed [24:0] e;
	logic               neg_q;
	logic [gts_pkg::AREA_W-1:0] area_q;

	gts_pkg::crd_t bx [3];
	gts_pkg::crd_t by [3];
	gts_pkg::crd_t ox_q [3];
	gts_pkg::crd_t oy_q [3];
	logic [gts_pkg::COL_W-1:0] oc_q [3];

	gts_pkg::crd_t xlo, xhi, ylo, yhi;
	gts_pkg::crd_t xmn, xmx, ymn, ymx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				vc_q[i] <= '0;
			end
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= '0;
			bottom_q <= '0;
			offx_q   <= '0;
			offy_q   <= '0;
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (load_we && slot == 2'(i)) begin
					vx_q[i] <= vx;
					vy_q[i] <= vy;
					vc_q[i] <= vc;
				end
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					gts_pkg::REG_DRAW_LEFT:   left_q   <= cfg_data[gts_pkg::BX_W-1:0];
					gts_pkg::REG_DRAW_TOP:    top_q    <= cfg_data[gts_pkg::BY_W-1:0];
					gts_pkg::REG_DRAW_RIGHT:  right_q  <= cfg_data[gts_pkg::BX_W-1:0];
					gts_pkg::REG_DRAW_BOTTOM: bottom_q <= cfg_data[gts_pkg::BY_W-1:0];
					gts_pkg::REG_OFFSET_X:    offx_q   <= cfg_data;
					gts_pkg::REG_OFFSET_Y:    offy_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Winding of the raw vertices; the offset does not change it.
	assign dx1 = 12'(vx_q[1]) - 12'(vx_q[0]);
	assign dy2 = 12'(vy_q[2]) - 12'(vy_q[0]);
	assign dy1 = 12'(vy_q[1]) - 12'(vy_q[0]);
	assign dx2 = 12'(vx_q[2]) - 12'(vx_q[0]);
	assign e   = 25'(pa_q) - 25'(pb_q);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bx[i] = gts_pkg::crd_t'(vx_q[i]) + gts_pkg::crd_t'(offx_q);
			by[i] = gts_pkg::crd_t'(vy_q[i]) + gts_pkg::crd_t'(offy_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q   <= '0;
			pb_q   <= '0;
			neg_q  <= 1'b0;
			area_q <= '0;
			for (int i = 0; i < 3; i++) begin
				ox_q[i] <= '0;
				oy_q[i] <= '0;
				oc_q[i] <= '0;
			end
		end else begin
			pa_q   <= dx1 * dy2;
			pb_q   <= dy1 * dx2;
			neg_q  <= e[24];
			area_q <= e[24] ? gts_pkg::AREA_W'(-e) : gts_pkg::AREA_W'(e);
			// A negative winding swaps the roles of vertices 1 and 2.
			ox_q[0] <= bx[0];
			oy_q[0] <= by[0];
			oc_q[0] <= vc_q[0];
			ox_q[1] <= neg_q ? bx[2] : bx[1];
			oy_q[1] <= neg_q ? by[2] : by[1];
			oc_q[1] <= neg_q ? vc_q[2] : vc_q[1];
			ox_q[2] <= neg_q ? bx[1] : bx[2];
			oy_q[2] <= neg_q ? by[1] : by[2];
			oc_q[2] <= neg_q ? vc_q[1] : vc_q[2];
		end
	end

	// The box does not depend on vertex order, so it follows the registers directly.
	always_comb begin
		xmn = (bx[0] < bx[1]) ? bx[0] : bx[1];
		xmn = (bx[2] < xmn) ? bx[2] : xmn;
		xmx = (bx[0] > bx[1]) ? bx[0] : bx[1];
		xmx = (bx[2] > xmx) ? bx[2] : xmx;
		ymn = (by[0] < by[1]) ? by[0] : by[1];
		ymn = (by[2] < ymn) ? by[2] : ymn;
		ymx = (by[0] > by[1]) ? by[0] : by[1];
		ymx = (by[2] > ymx) ? by[2] : ymx;

		xlo = (xmn > gts_pkg::crd_t'(left_q)) ? xmn : gts_pkg::crd_t'(left_q);
		ylo = (ymn > gts_pkg::crd_t'(top_q)) ? ymn : gts_pkg::crd_t'(top_q);
		xhi = (xmx < gts_pkg::crd_t'(right_q)) ? xmx : gts_pkg::crd_t'(right_q);
		yhi = (ymx < gts_pkg::crd_t'(bottom_q)) ? ymx : gts_pkg::crd_t'(bottom_q);

		geo.xmin = (xlo > gts_pkg::crd_t'(gts_pkg::BOX_X_LIM)) ? gts_pkg::BOX_X_LIM
			: xlo[gts_pkg::BX_W-1:0];
		geo.ymin = (ylo > gts_pkg::crd_t'(gts_pkg::BOX_Y_LIM)) ? gts_pkg::BOX_Y_LIM
			: ylo[gts_pkg::BY_W-1:0];
		geo.xmax = (xhi < 0) ? '0 : xhi[gts_pkg::BX_W-1:0];
		geo.ymax = (yhi < 0) ? '0 : yhi[gts_pkg::BY_W-1:0];

		for (int i = 0; i < 3; i++) begin
			geo.ox[i] = ox_q[i];
			geo.oy[i] = oy_q[i];
			geo.oc[i] = oc_q[i];
		end
		geo.area = area_q;
	end

endmodule

FILE: src/gts_div.sv
// Pipelined restoring divider for three color channels, one quotient bit per stage.
module gts_div (
	input  logic                                clk,
	input  logic [gts_pkg::QUO_W-1:0]           en,
	input  logic [2:0][gts_pkg::SUM_W-1:0]      rem_in,
	input  logic [gts_pkg::AREA_W-1:0]          area_in,
	input  gts_pkg::side_t                      side_in,
	output logic [2:0][gts_pkg::QUO_W-1:0]      quo,
	output gts_pkg::side_t                      side_out
);

	logic [2:0][gts_pkg::SUM_W-1:0]   rem_stg  [gts_pkg::QUO_W];
	logic [2:0][gts_pkg::QUO_W-1:0]   quo_stg  [gts_pkg::QUO_W];
	logic [gts_pkg::AREA_W-1:0]       area_stg [gts_pkg::QUO_W];
	gts_pkg::side_t                   side_stg [gts_pkg::QUO_W];

	for (genvar k = 0; k < gts_pkg::QUO_W; k++) begin : g_step
		localparam int B = gts_pkg::QUO_W - 1 - k;

		logic [2:0][gts_pkg::SUM_W-1:0] rem_prev;
		logic [2:0][gts_pkg::QUO_W-1:0] quo_prev;
		logic [gts_pkg::AREA_W-1:0]     area_prev;
		gts_pkg::side_t                 side_prev;
		logic [gts_pkg::SUM_W-1:0]      trial;

		if (k == 0) begin : g_first
			assign rem_prev  = rem_in;
			assign quo_prev  = '0;
			assign area_prev = area_in;
			assign side_prev = side_in;
		end else begin : g_next
			assign rem_prev  = rem_stg[k-1];
			assign quo_prev  = quo_stg[k-1];
			assign area_prev = area_stg[k-1];
			assign side_prev = side_stg[k-1];
		end

		assign trial = gts_pkg::SUM_W'(area_prev) << B;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				for (int c = 0; c < 3; c++) begin
					if (rem_prev[c] >= trial) begin
						rem_stg[k][c] <= rem_prev[c] - trial;
						quo_stg[k][c] <= quo_prev[c] | (gts_pkg::QUO_W'(1) << B);
					end else begin
						rem_stg[k][c] <= rem_prev[c];
						quo_stg[k][c] <= quo_prev[c];
					end
				end
				area_stg[k] <= area_prev;
				side_stg[k] <= side_prev;
			end
		end
	end

	assign quo      = quo_stg[gts_pkg::QUO_W-1];
	assign side_out = side_stg[gts_pkg::QUO_W-1];

endmodule

FILE: src/gouraud_triangle_pixel_shader_top.sv
// Top level of the Gouraud triangle pixel shader: stream ports, pixel pipeline and output stage.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  s_tuser operation, s_tdata vertex and pixel fields
//  m_*      out        m_tvalid / m_tready  m_tuser pixel_write, m_tdata address, color, box
//  cfg_*    in         cfg_we               cfg_addr register index, cfg_data value
//
// Every item gives one result; pixels enter one per clock while the output does not stall and no setup hold is on.
// After a vertex load or a register write the input is held off while
// the three-stage setup pipeline (winding multipliers, area, vertex order) settles.
// Reset clears the vertex and clip registers, the setup state and all stage valid bits.
// A stalled output holds its result; upstream stages keep filling empty slots, and a
// full pipeline holds every stage in place, so nothing is dropped or repeated.
module gouraud_triangle_pixel_shader_top #(
	parameter int LINE_WIDTH = gts_pkg::LINE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// vertex_slot[1:0], vertex_x[12:2], vertex_y[23:13], vertex_color[47:24],
	// pixel_x[57:48], pixel_y[66:58], zero fill above
	input  logic [71:0]                         s_tdata,
	// operation[0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// vram_address[18:0], pixel_bgr555[33:19], box_x_min[43:34], box_y_min[52:44],
	// box_x_max[62:53], box_y_max[71:63]
	output logic [71:0]                         m_tdata,
	// pixel_write[0]
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [gts_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [gts_pkg::CFG_W-1:0]           cfg_data
);

	localparam int NSTG = 15;
	localparam int DIV0 = 7;
	localparam logic [1:0] SETUP_HOLD = 2'd2;
	localparam logic [11:0] LW = 12'(LINE_WIDTH);

	// Input fields.
	logic                               in_op;
	logic [1:0]                         in_slot;
	logic signed [gts_pkg::VX_W-1:0]    in_vx, in_vy;
	logic [gts_pkg::COL_W-1:0]          in_vc;
	logic [gts_pkg::BX_W-1:0]           in_px;
	logic [gts_pkg::BY_W-1:0]           in_py;

	assign in_op   = s_tuser;
	assign in_slot = s_tdata[1:0];
	assign in_vx   = s_tdata[12:2];
	assign in_vy   = s_tdata[23:13];
	assign in_vc   = s_tdata[47:24];
	assign in_px   = s_tdata[57:48];
	assign in_py   = s_tdata[66:58];

	logic acc, load_we;
	logic [1:0] busy_q;
	logic [NSTG:1] vld, rdy;

	gts_pkg::geo_t geo;

	assign acc     = s_tvalid && s_tready;
	assign load_we = acc && (in_op == gts_pkg::OP_LOAD);

	gts_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_we  (load_we),
		.slot     (in_slot),
		.vx       (in_vx),
		.vy       (in_vy),
		.vc       (in_vc),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.geo      (geo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (load_we || cfg_we) begin
			busy_q <= SETUP_HOLD;
		end else if (busy_q != 2'd0) begin
			busy_q <= busy_q - 2'd1;
		end
	end

	// Stage valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s15;
	logic [gts_pkg::QUO_W-1:0] v_div, v_div_in;

	// Valid bit entering each divider stage.
	assign v_div_in = {v_div[gts_pkg::QUO_W-2:0], v_s6};

	always_comb begin
		vld[1]  = v_s1;
		vld[2]  = v_s2;
		vld[3]  = v_s3;
		vld[4]  = v_s4;
		vld[5]  = v_s5;
		vld[6]  = v_s6;
		for (int k = 0; k < gts_pkg::QUO_W; k++) vld[DIV0 + k] = v_div[k];
		vld[NSTG] = v_s15;
		rdy[NSTG] = !vld[NSTG] || m_tready;
		for (int i = NSTG - 1; i >= 1; i--) rdy[i] = !vld[i] || rdy[i+1];
	end

	assign s_tready = rdy[1] && (busy_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_div <= '0;
			v_s15 <= 1'b0;
		end else begin
			if (rdy[1]) v_s1 <= acc;
			if (rdy[2]) v_s2 <= v_s1;
			if (rdy[3]) v_s3 <= v_s2;
			if (rdy[4]) v_s4 <= v_s3;
			if (rdy[5]) v_s5 <= v_s4;
			if (rdy[6]) v_s6 <= v_s5;
			for (int k = 0; k < gts_pkg::QUO_W; k++) begin
				if (rdy[DIV0 + k]) v_div[k] <= v_div_in[k];
			end
			if (rdy[NSTG]) v_s15 <= v_div[gts_pkg::QUO_W-1];
		end
	end

	// Stage 1: captured item.
	logic                     op_s1;
	logic [gts_pkg::BX_W-1:0] px_s1;
	logic [gts_pkg::BY_W-1:0] py_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			op_s1 <= in_op;
			px_s1 <= in_px;
			py_s1 <= in_py;
		end
	end

	// Stage 2: edge operand differences and the box.
	logic signed [gts_pkg::DIF_W-1:0] pxw, pyw;
	logic signed [gts_pkg::DIF_W-1:0] xw [3];
	logic signed [gts_pkg::DIF_W-1:0] yw [3];

	logic                              op_s2;
	logic [gts_pkg::BX_W-1:0]          px_s2, xmin_s2, xmax_s2;
	logic [gts_pkg::BY_W-1:0]          py_s2, ymin_s2, ymax_s2;
	logic [gts_pkg::AREA_W-1:0]        area_s2;
	logic [2:0][gts_pkg::COL_W-1:0]    oc_s2;
	logic signed [gts_pkg::DIF_W-1:0]  ea_s2 [3];
	logic signed [gts_pkg::DIF_W-1:0]  eb_s2 [3];
	logic signed [gts_pkg::DIF_W-1:0]  ec_s2 [3];
	logic signed [gts_pkg::DIF_W-1:0]  ed_s2 [3];

	always_comb begin
		pxw = gts_pkg::DIF_W'(px_s1);
		pyw = gts_pkg::DIF_W'(py_s1);
		for (int i = 0; i < 3; i++) begin
			xw[i] = gts_pkg::DIF_W'($signed(geo.ox[i]));
			yw[i] = gts_pkg::DIF_W'($signed(geo.oy[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			op_s2   <= op_s1;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			xmin_s2 <= geo.xmin;
			ymin_s2 <= geo.ymin;
			xmax_s2 <= geo.xmax;
			ymax_s2 <= geo.ymax;
			area_s2 <= geo.area;
			oc_s2   <= geo.oc;
			// Edge i is opposite vertex i.
			ea_s2[0] <= xw[2] - xw[1];
			eb_s2[0] <= pyw - yw[1];
			ec_s2[0] <= yw[2] - yw[1];
			ed_s2[0] <= pxw - xw[1];
			ea_s2[1] <= xw[0] - xw[2];
			eb_s2[1] <= pyw - yw[2];
			ec_s2[1] <= yw[0] - yw[2];
			ed_s2[1] <= pxw - xw[2];
			ea_s2[2] <= xw[1] - xw[0];
			eb_s2[2] <= pyw - yw[0];
			ec_s2[2] <= yw[1] - yw[0];
			ed_s2[2] <= pxw - xw[0];
		end
	end

	// Stage 3: edge products, box test, dither pick, address.
	logic signed [gts_pkg::PRD_W-1:0]  pm_s3 [3];
	logic signed [gts_pkg::PRD_W-1:0]  pn_s3 [3];
	logic                              inbox_s3;
	logic signed [gts_pkg::DTH_W-1:0]  dith_s3;
	logic [gts_pkg::ADDR_W-1:0]        addr_s3;
	logic [gts_pkg::BX_W-1:0]          xmin_s3, xmax_s3;
	logic [gts_pkg::BY_W-1:0]          ymin_s3, ymax_s3;
	logic [gts_pkg::AREA_W-1:0]        area_s3;
	logic [2:0][gts_pkg::COL_W-1:0]    oc_s3;

	logic [1:0]  ddx, ddy;
	logic [20:0] row;

	assign ddx = px_s2[1:0] - xmin_s2[1:0];
	assign ddy = py_s2[1:0] - ymin_s2[1:0];
	assign row = py_s2 * LW;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int i = 0; i < 3; i++) begin
				pm_s3[i] <= ea_s2[i] * eb_s2[i];
				pn_s3[i] <= ec_s2[i] * ed_s2[i];
			end
			inbox_s3 <= (op_s2 == gts_pkg::OP_PIXEL) && (area_s2 != '0)
				&& (px_s2 >= xmin_s2) && (px_s2 < xmax_s2)
				&& (py_s2 >= ymin_s2) && (py_s2 < ymax_s2);
			dith_s3  <= gts_pkg::dither({ddy, ddx});
			addr_s3  <= gts_pkg::ADDR_W'(row + 21'(px_s2));
			xmin_s3  <= xmin_s2;
			ymin_s3  <= ymin_s2;
			xmax_s3  <= xmax_s2;
			ymax_s3  <= ymax_s2;
			area_s3  <= area_s2;
			oc_s3    <= oc_s2;
		end
	end

	// Stage 4: edge values and coverage.
	logic signed [gts_pkg::EDG_W-1:0]  z [3];
	logic [gts_pkg::AREA_W-1:0]        z_s4 [3];
	gts_pkg::side_t                    side_s4;
	logic [gts_pkg::AREA_W-1:0]        area_s4;
	logic [2:0][gts_pkg::COL_W-1:0]    oc_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			z[i] = gts_pkg::EDG_W'(pm_s3[i]) - gts_pkg::EDG_W'(pn_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			for (int i = 0; i < 3; i++) begin
				// A covered pixel has every edge value between zero and the area.
				z_s4[i] <= z[i][gts_pkg::AREA_W-1:0];
			end
			side_s4.wr   <= inbox_s3 && !z[0][gts_pkg::EDG_W-1] && !z[1][gts_pkg::EDG_W-1]
				&& !z[2][gts_pkg::EDG_W-1];
			side_s4.addr <= addr_s3;
			side_s4.dith <= dith_s3;
			side_s4.xmin <= xmin_s3;
			side_s4.ymin <= ymin_s3;
			side_s4.xmax <= xmax_s3;
			side_s4.ymax <= ymax_s3;
			area_s4      <= area_s3;
			oc_s4        <= oc_s3;
		end
	end

	// Stage 5: weight times channel.
	logic [gts_pkg::SUM_W-1:0]  zc_s5 [3][3];
	gts_pkg::side_t             side_s5;
	logic [gts_pkg::AREA_W-1:0] area_s5;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			for (int c = 0; c < 3; c++) begin
				for (int i = 0; i < 3; i++) begin
					zc_s5[c][i] <= z_s4[i] * oc_s4[i][gts_pkg::CH_W*c +: gts_pkg::CH_W];
				end
			end
			side_s5 <= side_s4;
			area_s5 <= area_s4;
		end
	end

	// Stage 6: weighted sums.
	logic [2:0][gts_pkg::SUM_W-1:0] sum_s6;
	gts_pkg::side_t                 side_s6;
	logic [gts_pkg::AREA_W-1:0]     area_s6;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			for (int c = 0; c < 3; c++) begin
				sum_s6[c] <= zc_s5[c][0] + zc_s5[c][1] + zc_s5[c][2];
			end
			side_s6 <= side_s5;
			area_s6 <= area_s5;
		end
	end

	// Stages 7 to 14: division by the area.
	logic [2:0][gts_pkg::QUO_W-1:0] quo;
	gts_pkg::side_t                 side_dv;

	gts_div u_div (
		.clk      (clk),
		.en       (rdy[DIV0 + gts_pkg::QUO_W - 1 : DIV0]),
		.rem_in   (sum_s6),
		.area_in  (area_s6),
		.side_in  (side_s6),
		.quo      (quo),
		.side_out (side_dv)
	);

	// Stage 15: dither, clamp, pack.
	function automatic logic [4:0] shade(input logic [gts_pkg::QUO_W-1:0] q,
	                                     input logic signed [gts_pkg::DTH_W-1:0] d);
		logic signed [9:0] qv, dv, sv;
		logic [7:0]        ch;
		qv = 10'(q);
		dv = 10'(d);
		sv = qv + dv;
		if (sv >= 10'sd255) ch = 8'hff;
		else if (sv <= 10'sd0) ch = 8'h00;
		else ch = sv[7:0];
		return ch[7:3];
	endfunction

	logic                          wr_s15;
	logic [gts_pkg::ADDR_W-1:0]    addr_s15;
	logic [14:0]                   col_s15;
	logic [gts_pkg::BX_W-1:0]      xmin_s15, xmax_s15;
	logic [gts_pkg::BY_W-1:0]      ymin_s15, ymax_s15;

	always_ff @(posedge clk) begin
		if (rdy[NSTG]) begin
			wr_s15   <= side_dv.wr;
			addr_s15 <= side_dv.wr ? side_dv.addr : '0;
			col_s15  <= side_dv.wr ? {shade(quo[2], side_dv.dith), shade(quo[1], side_dv.dith),
				shade(quo[0], side_dv.dith)} : '0;
			xmin_s15 <= side_dv.xmin;
			ymin_s15 <= side_dv.ymin;
			xmax_s15 <= side_dv.xmax;
			ymax_s15 <= side_dv.ymax;
		end
	end

	assign m_tvalid = v_s15;
	assign m_tuser  = wr_s15;
	assign m_tdata  = {ymax_s15, xmax_s15, ymin_s15, xmin_s15, col_s15, addr_s15};

endmodule

FILE: verif/gts_checker.sv
// Checker for the Gouraud shader: predicts every result from the input transfers and compares.
`timescale 1ns / 1ps

module gts_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [71:0]                   s_tdata,
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [71:0]                   m_tdata,
	input  logic                          m_tuser,
	input  logic                          cfg_we,
	input  logic [gts_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [gts_pkg::CFG_W-1:0]     cfg_data,
	output int                            errors,
	output int                            pending
);

	typedef struct {
		bit        wr;
		bit [18:0] addr;
		bit [14:0] bgr;
		bit [9:0]  xmin;
		bit [8:0]  ymin;
		bit [9:0]  xmax;
		bit [8:0]  ymax;
	} shade_result_t;

	localparam int ORDERED_DITHER [16] = '{-4, 0, -3, 1, 2, -2, 3, -1,
		-3, 1, -4, 0, 3, -1, 2, -2};

	shade_result_t expected_pixels[$];

	bit [9:0]  clip_left, clip_right;
	bit [8:0]  clip_top, clip_bottom;
	bit [10:0] shift_x, shift_y;
	bit [10:0] vert_x [3];
	bit [10:0] vert_y [3];
	bit [23:0] vert_rgb [3];

	longint    tri_x [3];
	longint    tri_y [3];
	bit [23:0] tri_rgb [3];
	longint    area2;
	longint    box [4];

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic longint edge_eq(longint ax, longint ay, longint bx, longint by,
		longint cx, longint cy);
		return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
	endfunction

	function automatic longint clamp_to(longint v, longint hi);
		if (v < 0)
			return 0;
		return (v > hi) ? hi : v;
	endfunction

	function automatic longint min_of(longint v [3]);
		longint m;
		m = (v[0] < v[1]) ? v[0] : v[1];
		return (m < v[2]) ? m : v[2];
	endfunction

	function automatic longint max_of3(longint v [3]);
		longint m;
		m = (v[0] > v[1]) ? v[0] : v[1];
		return (m > v[2]) ? m : v[2];
	endfunction

	function automatic longint max_of(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint min_of2(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	// Orders the vertices counter-clockwise, applies the offset, clips the box.
	function automatic void rebuild_triangle();
		longint xs [3];
		longint ys [3];
		int     b;
		int     c;
		for (int i = 0; i < 3; i++) begin
			xs[i] = longint'($signed(vert_x[i]));
			ys[i] = longint'($signed(vert_y[i]));
		end
		b = 1;
		c = 2;
		if (edge_eq(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]) < 0) begin
			b = 2;
			c = 1;
		end
		tri_x[0] = xs[0] + shift_x;  tri_y[0] = ys[0] + shift_y;
		tri_x[1] = xs[b] + shift_x;  tri_y[1] = ys[b] + shift_y;
		tri_x[2] = xs[c] + shift_x;  tri_y[2] = ys[c] + shift_y;
		tri_rgb[0] = vert_rgb[0];
		tri_rgb[1] = vert_rgb[b];
		tri_rgb[2] = vert_rgb[c];
		box[0] = clamp_to(max_of(min_of(tri_x), clip_left), 1023);
		box[1] = clamp_to(max_of(min_of(tri_y), clip_top), 511);
		box[2] = clamp_to(min_of2(max_of3(tri_x), clip_right), 1023);
		box[3] = clamp_to(min_of2(max_of3(tri_y), clip_bottom), 511);
		area2 = edge_eq(tri_x[0], tri_y[0], tri_x[1], tri_y[1], tri_x[2], tri_y[2]);
	endfunction

	function automatic shade_result_t predict_pixel(bit op, bit [71:0] d);
		shade_result_t r;
		longint px;
		longint py;
		longint z [3];
		longint sum;
		longint v;
		int     dith;
		r = '{default: 0};
		if (op == gts_pkg::OP_LOAD) begin
			if (d[1:0] != 2'd3) begin
				vert_x[d[1:0]]   = d[12:2];
				vert_y[d[1:0]]   = d[23:13];
				vert_rgb[d[1:0]] = d[47:24];
				rebuild_triangle();
			end
		end else begin
			px = d[57:48];
			py = d[66:58];
			if (area2 > 0 && px >= box[0] && px < box[2] && py >= box[1] && py < box[3]) begin
				z[0] = edge_eq(tri_x[1], tri_y[1], tri_x[2], tri_y[2], px, py);
				z[1] = edge_eq(tri_x[2], tri_y[2], tri_x[0], tri_y[0], px, py);
				z[2] = edge_eq(tri_x[0], tri_y[0], tri_x[1], tri_y[1], px, py);
				if (z[0] >= 0 && z[1] >= 0 && z[2] >= 0) begin
					dith = ORDERED_DITHER[((px - box[0]) & 3) + 4 * ((py - box[1]) & 3)];
					for (int ch = 0; ch < 3; ch++) begin
						sum = 0;
						for (int k = 0; k < 3; k++)
							sum += z[k] * longint'((tri_rgb[k] >> (8 * ch)) & 8'hff);
						v = sum / area2 + dith;
						if (v > 255)
							v = 255;
						if (v < 0)
							v = 0;
						r.bgr |= 15'(v >> 3) << (5 * ch);
					end
					r.wr   = 1'b1;
					r.addr = 19'(px + py * 1024);
				end
			end
		end
		r.xmin = 10'(box[0]);
		r.ymin = 9'(box[1]);
		r.xmax = 10'(box[2]);
		r.ymax = 9'(box[3]);
		return r;
	endfunction

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shade_result_t e;
		if (!arst_n) begin
			clip_left = 0; clip_top = 0; clip_right = 0; clip_bottom = 0;
			shift_x = 0; shift_y = 0;
			for (int i = 0; i < 3; i++) begin
				vert_x[i] = 0; vert_y[i] = 0; vert_rgb[i] = 0;
			end
			rebuild_triangle();
			expected_pixels.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					gts_pkg::REG_DRAW_LEFT:   clip_left   = cfg_data[9:0];
					gts_pkg::REG_DRAW_TOP:    clip_top    = cfg_data[8:0];
					gts_pkg::REG_DRAW_RIGHT:  clip_right  = cfg_data[9:0];
					gts_pkg::REG_DRAW_BOTTOM: clip_bottom = cfg_data[8:0];
					gts_pkg::REG_OFFSET_X:    shift_x     = cfg_data;
					gts_pkg::REG_OFFSET_Y:    shift_y     = cfg_data;
					default: ;
				endcase
				rebuild_triangle();
			end
			if (s_tvalid && s_tready)
				expected_pixels.push_back(predict_pixel(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("output transfer with no result expected");
					errors++;
				end else begin
					e = expected_pixels.pop_front();
					check_field("pixel_write", e.wr, m_tuser);
					check_field("vram_address", e.addr, m_tdata[18:0]);
					check_field("pixel_bgr555", e.bgr, m_tdata[33:19]);
					check_field("box_x_min", e.xmin, m_tdata[43:34]);
					check_field("box_y_min", e.ymin, m_tdata[52:44]);
					check_field("box_x_max", e.xmax, m_tdata[62:53]);
					check_field("box_y_max", e.ymax, m_tdata[71:63]);
				end
			end
		end
		pending = expected_pixels.size();
	end

endmodule

FILE: verif/tb.sv
// Testbench top for the Gouraud shader: reset, register settings, triangle and pixel stimulus.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 400000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [71:0]                   s_tdata = '0;
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [71:0]                   m_tdata;
	logic                          m_tuser;
	logic                          cfg_we = 1'b0;
	logic [gts_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
	logic [gts_pkg::CFG_W-1:0]     cfg_data = '0;

	int errors;
	int pending;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int stall_requests = 0;
	int cycles = 0;
	int sent = 0;
	int off_x = 0;
	int off_y = 0;

	gouraud_triangle_pixel_shader_top u_dut (.*);

	gts_checker u_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver side; a stall request blocks the output for a long stretch.
	always @(negedge clk) begin
		static int stalls_seen = 0;
		static int stall_left = 0;
		if (stall_requests != stalls_seen) begin
			stalls_seen = stall_requests;
			stall_left  = 400;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic push_item(bit op, bit [1:0] slot, int vx, int vy, bit [23:0] rgb,
		int px, int py);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'd0, 9'(py), 10'(px), rgb, 11'(vy), 11'(vx), slot};
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
		@(negedge clk);
	endtask

	task automatic load_vertex(bit [1:0] slot, int vx, int vy, bit [23:0] rgb);
		push_item(gts_pkg::OP_LOAD, slot, vx, vy, rgb, $urandom_range(1023),
			$urandom_range(511));
	endtask

	task automatic shade_at(int px, int py);
		push_item(gts_pkg::OP_PIXEL, $urandom_range(3), $urandom_range(2047),
			$urandom_range(2047), $urandom, px, py);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [gts_pkg::CFG_IDX_W-1:0] idx, int value);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= gts_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_we   <= 1'b0;
		if (idx == gts_pkg::REG_OFFSET_X)
			off_x = value;
		if (idx == gts_pkg::REG_OFFSET_Y)
			off_y = value;
	endtask

	task automatic set_window(int left, int top, int right, int bottom, int ox, int oy);
		write_reg(gts_pkg::REG_DRAW_LEFT, left);
		write_reg(gts_pkg::REG_DRAW_TOP, top);
		write_reg(gts_pkg::REG_DRAW_RIGHT, right);
		write_reg(gts_pkg::REG_DRAW_BOTTOM, bottom);
		write_reg(gts_pkg::REG_OFFSET_X, ox);
		write_reg(gts_pkg::REG_OFFSET_Y, oy);
	endtask

	function automatic int fit_vertex(int v);
		if (v < -1024)
			return -1024;
		return (v > 1023) ? 1023 : v;
	endfunction

	// One triangle near a random screen point, then pixels mostly around it.
	task automatic random_triangle();
		int cx;
		int cy;
		int n;
		cx = $urandom_range(960, 60);
		cy = $urandom_range(450, 60);
		for (int k = 0; k < 3; k++)
			load_vertex(k, fit_vertex(cx + $urandom_range(120) - 60 - off_x),
				fit_vertex(cy + $urandom_range(120) - 60 - off_y), $urandom);
		n = $urandom_range(12, 4);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0)
				shade_at($urandom_range(1023), $urandom_range(511));
			else
				shade_at(cx + $urandom_range(130) - 65, cy + $urandom_range(130) - 65);
		end
	endtask

	task automatic random_noise();
		push_item($urandom_range(1), $urandom_range(3), $urandom_range(2047),
			$urandom_range(2047), $urandom, $urandom_range(1023), $urandom_range(511));
	endtask

	task automatic random_run(int count);
		int target;
		target = sent + count;
		while (sent < target) begin
			if ($urandom_range(99) < 15)
				random_noise();
			else
				random_triangle();
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_window(0, 0, 1023, 511, 0, 0);
		write_reg(3'd6, 55);
		write_reg(3'd7, 2047);

		// Directed: zero area, both windings, slot swap, edges, extremes.
		shade_at(0, 0);
		load_vertex(0, 0, 0, 24'h0000ff);
		load_vertex(1, 100, 0, 24'h00ff00);
		load_vertex(2, 0, 100, 24'hff0000);
		shade_at(10, 10);
		shade_at(0, 0);
		shade_at(90, 90);
		shade_at(200, 200);
		load_vertex(1, 0, 100, 24'hffffff);
		load_vertex(2, 100, 0, 24'h000000);
		shade_at(33, 33);
		shade_at(1, 98);
		load_vertex(3, 500, 500, 24'h123456);
		shade_at(20, 20);
		load_vertex(0, -1024, -1024, 24'hffffff);
		load_vertex(1, 1023, -1024, 24'hffffff);
		load_vertex(2, 1023, 1023, 24'hffffff);
		shade_at(1023, 511);
		shade_at(1022, 510);
		shade_at(600, 100);
		load_vertex(2, 0, 0, 24'h808080);
		shade_at(5, 0);
		wait_idle();

		// Sender rarely idle, receiver mostly stalled.
		send_gap_pct = 18;
		recv_gap_pct = 74;
		set_window(0, 0, 1023, 511, 0, 0);
		random_run(180);
		wait_idle();

		// The other way round, clipped window with an offset.
		send_gap_pct = 74;
		recv_gap_pct = 18;
		set_window($urandom_range(200), $urandom_range(100), $urandom_range(1023, 800),
			$urandom_range(511, 400), $urandom_range(300), $urandom_range(200));
		random_run(170);
		wait_idle();

		// No idling: an inverted window with maximum offsets, then a long output stall.
		send_gap_pct = 0;
		recv_gap_pct = 0;
		set_window(1023, 511, 0, 0, 2047, 2047);
		random_run(20);
		wait_idle();
		set_window(0, 0, 1023, 511, 1024, 512);
		stall_requests++;
		random_run(180);
		wait_idle();

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: gouraud_triangle_pixel_shader_top.f
src/gts_pkg.sv
src/gts_setup.sv
src/gts_div.sv
src/gouraud_triangle_pixel_shader_top.sv
verif/gts_checker.sv
verif/tb.sv
